>>> rtl/core/conv2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_pkg
// Shared widths, register indexes and types of the 3x3 zero-padded
// convolution block.
// ----------------------------------------------------------------------------
package conv2d_pkg;

  // build-time defaults and fixed geometry
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int KERNEL_SIZE   = 3;
  localparam int MAX_HEIGHT    = 4096;

  // field widths
  localparam int PIXEL_W      = 8;
  localparam int COEF_W       = 8;
  localparam int KROW_W       = KERNEL_SIZE * COEF_W;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int ROW_W        = 13;                  // input row runs to height+1
  localparam int OUT_ROW_W    = $clog2(MAX_HEIGHT);  // result row stays below height
  localparam int PROD_W       = COEF_W + PIXEL_W + 1;
  localparam int RESULT_W     = 20;
  localparam int LINE_W       = 2 * PIXEL_W;

  // register reset values
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  // item opcode for a frame pixel
  localparam logic OP_PIXEL = 1'b0;

  // per-item control carried from the sequencer to the datapath
  typedef struct packed {
    logic               emit;
    logic               last;
    logic               top_ok;
    logic               bot_ok;
    logic               left_ok;
    logic               right_ok;
    logic [PIXEL_W-1:0] px;
  } conv2d_tag_t;

  // kernel rows, row 0 on top, left coefficient in the low byte
  typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel_t;

endpackage
`default_nettype wire

>>> rtl/core/conv2d_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_seq
// Configuration registers and frame position counters. Tags each accepted
// item with its pixel, result flag and edge masks, and issues the line
// store read for its column.
// ----------------------------------------------------------------------------
module conv2d_seq import conv2d_pkg::*; #(
  parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_accept,
  input  wire logic                  in_opcode,
  input  wire logic [PIXEL_W-1:0]    in_pixel,
  input  wire logic                  adv,
  output logic                       rd_en,
  output logic [COL_W-1:0]           rd_addr,
  output logic                       s1_valid,
  output logic [COL_W-1:0]           s1_addr,
  output conv2d_tag_t                s1_tag,
  output kernel_t                    kernel
);

  localparam int RstWidth = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [COL_W-1:0]     w_last_r, w_last_nxt;
  logic [OUT_ROW_W-1:0] h_last_r, h_last_nxt;
  kernel_t              kernel_r, kernel_nxt;
  logic [COL_W-1:0]     in_col_r, in_col_nxt;
  logic [ROW_W-1:0]     in_row_r, in_row_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic                 s1_valid_r;
  logic [COL_W-1:0]     s1_addr_r;
  conv2d_tag_t          s1_tag_r;
  conv2d_tag_t          tag;
  logic                 in_frame;
  logic [WIDTH_REG_W-1:0]  wv;
  logic [HEIGHT_REG_W-1:0] hv;

  // configuration writes, width and height clamped into range on the way in
  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    kernel_nxt = kernel_r;
    wv         = cfg_wdata[WIDTH_REG_W-1:0];
    hv         = cfg_wdata[HEIGHT_REG_W-1:0];
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (wv == '0) begin
            w_last_nxt = '0;
          end else if (32'(wv) >= 32'(MAX_WIDTH)) begin
            w_last_nxt = COL_W'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = COL_W'(wv - 1'b1);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (hv == '0) begin
            h_last_nxt = '0;
          end else if (32'(hv) >= 32'(MAX_HEIGHT)) begin
            h_last_nxt = OUT_ROW_W'(MAX_HEIGHT - 1);
          end else begin
            h_last_nxt = OUT_ROW_W'(hv - 1'b1);
          end
        end
        REG_KERNEL_TOP:    kernel_nxt[0] = cfg_wdata[KROW_W-1:0];
        REG_KERNEL_MIDDLE: kernel_nxt[1] = cfg_wdata[KROW_W-1:0];
        REG_KERNEL_BOTTOM: kernel_nxt[2] = cfg_wdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // item tag: result position trails the input position by one row and one column
  always_comb begin
    in_frame     = in_row_r <= {1'b0, h_last_r};
    tag.px       = (in_opcode == OP_PIXEL && in_frame) ? in_pixel : '0;
    tag.emit     = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
    tag.last     = tag.emit && out_row_r == h_last_r && out_col_r == w_last_r;
    tag.top_ok   = out_row_r != '0;
    tag.bot_ok   = out_row_r != h_last_r;
    tag.left_ok  = out_col_r != '0;
    tag.right_ok = out_col_r != w_last_r;
  end

  // position counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (in_accept) begin
      if (tag.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (in_col_r == w_last_r) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + ROW_W'(1);
        end else begin
          in_col_nxt = in_col_r + COL_W'(1);
        end
        if (tag.emit) begin
          if (out_col_r == w_last_r) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + OUT_ROW_W'(1);
          end else begin
            out_col_nxt = out_col_r + COL_W'(1);
          end
        end
      end
    end
    // a new width or height starts a new frame
    if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= COL_W'(RstWidth - 1);
      h_last_r   <= OUT_ROW_W'(HEIGHT_RESET - 1);
      kernel_r   <= '0;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      w_last_r  <= w_last_nxt;
      h_last_r  <= h_last_nxt;
      kernel_r  <= kernel_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (adv) begin
        s1_valid_r <= in_accept;
      end
    end
  end

  // stage-one payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tag_r  <= tag;
      s1_addr_r <= in_col_r;
    end
  end

  assign rd_en    = in_accept;
  assign rd_addr  = in_col_r;
  assign s1_valid = s1_valid_r;
  assign s1_addr  = s1_addr_r;
  assign s1_tag   = s1_tag_r;
  assign kernel   = kernel_r;

  // the final result of a frame puts the input position back to the frame start
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && tag.last |=> in_col_r == '0 && in_row_r == '0 && out_row_r == '0)
    else $error("counters not restarted after final result");

  // the result position never runs past the configured frame
  a_out_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r <= w_last_r && out_row_r <= h_last_r && in_col_r <= w_last_r)
    else $error("position counter outside frame");

endmodule
`default_nettype wire

>>> rtl/core/conv2d_line_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_line_mem
// Line store: one entry per column holding the pixels of the two rows
// above. Read at accept, rewritten shifted up as its item leaves stage
// one; a write and read of the same column in one cycle is forwarded.
// ----------------------------------------------------------------------------
module conv2d_line_mem import conv2d_pkg::*; #(
  parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire logic [COL_W-1:0]   rd_addr,
  input  wire logic               wr_en,
  input  wire logic [COL_W-1:0]   wr_addr,
  input  wire logic [PIXEL_W-1:0] wr_px,
  output logic [LINE_W-1:0]       line_data
);

  logic [LINE_W-1:0] mem_r [MAX_WIDTH];
  logic [LINE_W-1:0] rd_data_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic              fwd_r;
  logic [LINE_W-1:0] wr_data;

  // upper byte is two rows up, lower byte one row up
  assign line_data = fwd_r ? fwd_data_r : rd_data_r;
  assign wr_data   = {line_data[PIXEL_W-1:0], wr_px};

  // storage, read before write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // bypass for a column read in the cycle it is rewritten
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en && wr_addr == rd_addr |=> fwd_r && fwd_data_r == $past(wr_data))
    else $error("same-column rewrite not forwarded");

endmodule
`default_nettype wire

>>> rtl/core/conv2d_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_mac
// 3x3 window shift register, nine masked coefficient products, adder tree
// and the result register.
// ----------------------------------------------------------------------------
module conv2d_mac import conv2d_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               s1_valid,
  input  wire conv2d_tag_t        s1_tag,
  input  wire logic [LINE_W-1:0]  line_data,
  input  wire kernel_t            kernel,
  output logic                    out_valid,
  output logic [RESULT_W-1:0]     out_conv_value,
  output logic                    out_last
);

  typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIXEL_W-1:0] window_t;
  typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PROD_W-1:0]  prod_t;

  window_t               win_r, win_nxt;
  prod_t                 prod_r, prod_nxt;
  logic                  p_valid_r;
  logic                  p_last_r;
  logic                  out_valid_r;
  logic [RESULT_W-1:0]   out_value_r;
  logic                  out_last_r;
  logic [RESULT_W-1:0]   sum;

  // window shift: new right column comes from the line store and the pixel
  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        win_nxt[r][c] = win_r[r][c+1];
      end
    end
    win_nxt[0][KERNEL_SIZE-1] = line_data[LINE_W-1:PIXEL_W];
    win_nxt[1][KERNEL_SIZE-1] = line_data[PIXEL_W-1:0];
    win_nxt[2][KERNEL_SIZE-1] = s1_tag.px;
  end

  // products, neighbors outside the frame forced to zero
  always_comb begin
    logic               row_ok;
    logic               col_ok;
    logic [PIXEL_W-1:0] pix;
    logic [COEF_W-1:0]  cf;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        row_ok = (r == 0) ? s1_tag.top_ok  : (r == KERNEL_SIZE - 1) ? s1_tag.bot_ok   : 1'b1;
        col_ok = (c == 0) ? s1_tag.left_ok : (c == KERNEL_SIZE - 1) ? s1_tag.right_ok : 1'b1;
        pix    = (row_ok && col_ok) ? win_nxt[r][c] : '0;
        cf     = kernel[r][c*COEF_W +: COEF_W];
        prod_nxt[r][c] = {{(PROD_W-COEF_W){cf[COEF_W-1]}}, cf}
                       * {{(PROD_W-PIXEL_W){1'b0}}, pix};
      end
    end
  end

  // adder tree over the registered products
  always_comb begin
    sum = '0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        sum = sum + {{(RESULT_W-PROD_W){prod_r[r][c][PROD_W-1]}}, prod_r[r][c]};
      end
    end
  end

  // window and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (s1_valid) begin
        win_r <= win_nxt;
      end
      p_valid_r   <= s1_valid && s1_tag.emit;
      out_valid_r <= p_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r      <= prod_nxt;
      p_last_r    <= s1_tag.last;
      out_value_r <= sum;
      out_last_r  <= p_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_conv_value = out_value_r;
  assign out_last       = out_last_r;

  a_result_from_product: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p_valid_r) && $past(adv))
    else $error("result raised without a product stage entry");

endmodule
`default_nettype wire

>>> rtl/core/conv2d_zero_padded_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_zero_padded_top
// Streaming 3x3 convolution with zero padding over a raster-order image,
// one 8-bit pixel per transfer, signed 8-bit kernel.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in_      | input     | in_valid / in_stall    | in_opcode, in_pixel
//  out_     | output    | out_valid / out_stall  | out_conv_value, out_last
//  cfg_     | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
//  One item per cycle sustained unless the output stalls; the line store
//  has one read and one write port, used once per item, and a same-column
//  rewrite is forwarded. After the transfer of the item that completes its
//  window, its result is registered at read, multiply and sum in turn.
//  Synchronous active-low reset clears counters, window and valids; the line
//  store is not cleared, as unwritten columns only feed masked neighbors.
//  A stalled full result register freezes the whole pipe and stalls input.
//
module conv2d_zero_padded_top import conv2d_pkg::*; #(
  parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [PIXEL_W-1:0]    in_pixel,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [RESULT_W-1:0]        out_conv_value,
  output logic                       out_last
);

  logic              adv;
  logic              in_accept;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  logic              s1_valid;
  logic [COL_W-1:0]  s1_addr;
  conv2d_tag_t       s1_tag;
  kernel_t           kernel;
  logic [LINE_W-1:0] line_data;

  // pipe advances unless a waiting result is held off
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  conv2d_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_opcode (in_opcode),
    .in_pixel  (in_pixel),
    .adv       (adv),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_addr   (s1_addr),
    .s1_tag    (s1_tag),
    .kernel    (kernel)
  );

  conv2d_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_en     (adv && s1_valid),
    .wr_addr   (s1_addr),
    .wr_px     (s1_tag.px),
    .line_data (line_data)
  );

  conv2d_mac u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .s1_valid       (s1_valid),
    .s1_tag         (s1_tag),
    .line_data      (line_data),
    .kernel         (kernel),
    .out_valid      (out_valid),
    .out_conv_value (out_conv_value),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
